>>> src/segment_intersection_point_core_assert.svh
// ----------------------------------------------------------------------------
// segment intersection assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_POINT_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_POINT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SIP_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("segment intersection check failed");
`define SIP_ASSERT_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("segment intersection check failed");
`else
`define SIP_ASSERT_ALWAYS(label, expr)
`define SIP_ASSERT_IMPLY(label, pre, post)
`endif
`endif

>>> src/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// shared types and width helpers of the segment intersection core
// ----------------------------------------------------------------------------
package sip_pkg;

	// queue depth between the product front and the divider back
	localparam int QUEUE_DEPTH = 4;

	// queue fill status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} sip_q_stat_t;

	// determinant denominator width
	function automatic int den_width(input int w);
		return 2 * w + 3;
	endfunction

	// cross product of one segment's endpoints
	function automatic int cprod_width(input int w);
		return 2 * w + 1;
	endfunction

	// numerator width
	function automatic int num_width(input int w);
		return 3 * w + 3;
	endfunction

	// word passed through the queue: den, nx, ny and four overlap bounds
	function automatic int front_word_width(input int w);
		return den_width(w) + 2 * num_width(w) + 4 * w;
	endfunction

endpackage

>>> src/sip_if.sv
// ----------------------------------------------------------------------------
// sip interfaces
// valid/ready channels for segment pairs and intersection results
// ----------------------------------------------------------------------------
interface sip_pair_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] a_upper_x;
	logic signed [COORD_WIDTH-1:0] a_upper_y;
	logic signed [COORD_WIDTH-1:0] a_lower_x;
	logic signed [COORD_WIDTH-1:0] a_lower_y;
	logic signed [COORD_WIDTH-1:0] b_upper_x;
	logic signed [COORD_WIDTH-1:0] b_upper_y;
	logic signed [COORD_WIDTH-1:0] b_lower_x;
	logic signed [COORD_WIDTH-1:0] b_lower_y;

	modport source (output valid, a_upper_x, a_upper_y, a_lower_x, a_lower_y,
		b_upper_x, b_upper_y, b_lower_x, b_lower_y, input ready);
	modport sink (input valid, a_upper_x, a_upper_y, a_lower_x, a_lower_y,
		b_upper_x, b_upper_y, b_lower_x, b_lower_y, output ready);
endinterface

interface sip_cross_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic hit;
	logic signed [COORD_WIDTH-1:0] cross_x;
	logic signed [COORD_WIDTH-1:0] cross_y;

	modport source (output valid, hit, cross_x, cross_y, input ready);
	modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

>>> src/segment_intersection_point_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_core
// exact intersection point of two integer line segments
// ----------------------------------------------------------------------------
// Each pair word carries two segments by their endpoints; each result word
// says whether they meet at a single point inside the overlap of both x
// ranges and both y ranges, and gives that point with the quotient truncated
// toward zero (zero coordinates when there is no hit). Parallel and collinear
// segments never hit. The core takes one pair word per clock and returns one
// result word per clock for as long as the result side keeps ready high.
// With an empty queue a word runs through the product pipeline, the queue,
// a register that forms the magnitudes, COORD_WIDTH divider stages (one
// quotient bit each) and the output register.
// A stall on the result side fills the four word queue before it reaches
// the pair side.
`include "segment_intersection_point_core_assert.svh"

module segment_intersection_point_core import sip_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sip_pair_if.sink    pair,
	sip_cross_if.source result
);

	localparam int FW = front_word_width(COORD_WIDTH);

	logic          push;
	logic          pop;
	logic [FW-1:0] front_word;
	logic [FW-1:0] back_word;
	sip_q_stat_t   q_stat;

	// front: differences, products, determinant and numerators
	sip_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.q_stat (q_stat),
		.push   (push),
		.word   (front_word)
	);

	// queue lets the divider stall without freezing the front right away
	sip_fifo #(
		.WIDTH(FW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_word),
		.pop    (pop),
		.rdata  (back_word),
		.stat   (q_stat)
	);

	// back: exact division and overlap test
	sip_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (back_word),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result)
	);

	// a miss always reports the origin
	`SIP_ASSERT_IMPLY(a_miss_zero, result.valid && !result.hit, result.cross_x == '0 && result.cross_y == '0)
	// front only pushes into a queue with room
	`SIP_ASSERT_IMPLY(a_push_room, push, !q_stat.full)
	// back only pops a queue holding a word
	`SIP_ASSERT_IMPLY(a_pop_data, pop, !q_stat.empty)

endmodule

>>> src/sip_fifo.sv
// ----------------------------------------------------------------------------
// sip_fifo
// small register queue decoupling the front and back pipelines
// ----------------------------------------------------------------------------
module sip_fifo import sip_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output sip_q_stat_t      stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// five stage product pipeline: differences, products, determinant, numerators
// ----------------------------------------------------------------------------
module sip_front import sip_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int FW = front_word_width(COORD_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	sip_pair_if.sink      pair,
	input  sip_q_stat_t   q_stat,
	output logic          push,
	output logic [FW-1:0] word
);

	localparam int W  = COORD_WIDTH;
	localparam int E  = W + 1;
	localparam int DW = den_width(W);
	localparam int CW = cprod_width(W);
	localparam int NW = num_width(W);
	localparam int L  = E;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage 1: coordinates and differences
	logic signed [W-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [E-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	// stage 2: products and overlap bounds
	logic signed [2*E-1:0] p1_s2, p2_s2;
	logic signed [2*W-1:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [E-1:0]   dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	logic signed [W-1:0]   lox_s2, hix_s2, loy_s2, hiy_s2;
	// stage 3: determinant and segment cross products
	logic signed [DW-1:0] den_s3;
	logic signed [CW-1:0] c12_s3, c34_s3;
	logic signed [E-1:0]  dx12_s3, dy12_s3, dx34_s3, dy34_s3;
	logic signed [W-1:0]  lox_s3, hix_s3, loy_s3, hiy_s3;
	// stage 4: split partial products of the numerators
	logic signed [W+E-1:0]   pxh_s4, qxh_s4, pyh_s4, qyh_s4;
	logic signed [L+1+E-1:0] pxl_s4, qxl_s4, pyl_s4, qyl_s4;
	logic signed [DW-1:0]    den_s4;
	logic signed [W-1:0]     lox_s4, hix_s4, loy_s4, hiy_s4;
	// stage 5: numerators
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic signed [DW-1:0] den_s5;
	logic signed [W-1:0]  lox_s5, hix_s5, loy_s5, hiy_s5;

	logic signed [W-1:0] lox_c, hix_c, loy_c, hiy_c;

	function automatic logic signed [W-1:0] smin(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return (a <= b) ? a : b;
	endfunction

	function automatic logic signed [W-1:0] smax(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		return (a >= b) ? a : b;
	endfunction

	assign en         = !valid_s5 || !q_stat.full;
	assign pair.ready = en;
	assign push       = valid_s5 && !q_stat.full;
	assign word       = {den_s5, nx_s5, ny_s5, lox_s5, hix_s5, loy_s5, hiy_s5};

	assign lox_c = smax(smin(x1_s1, x2_s1), smin(x3_s1, x4_s1));
	assign hix_c = smin(smax(x1_s1, x2_s1), smax(x3_s1, x4_s1));
	assign loy_c = smax(smin(y1_s1, y2_s1), smin(y3_s1, y4_s1));
	assign hiy_c = smin(smax(y1_s1, y2_s1), smax(y3_s1, y4_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pair.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= pair.a_upper_x;
			y1_s1   <= pair.a_upper_y;
			x2_s1   <= pair.a_lower_x;
			y2_s1   <= pair.a_lower_y;
			x3_s1   <= pair.b_upper_x;
			y3_s1   <= pair.b_upper_y;
			x4_s1   <= pair.b_lower_x;
			y4_s1   <= pair.b_lower_y;
			dx12_s1 <= E'(pair.a_upper_x) - E'(pair.a_lower_x);
			dy12_s1 <= E'(pair.a_upper_y) - E'(pair.a_lower_y);
			dx34_s1 <= E'(pair.b_upper_x) - E'(pair.b_lower_x);
			dy34_s1 <= E'(pair.b_upper_y) - E'(pair.b_lower_y);

			p1_s2   <= dx12_s1 * dy34_s1;
			p2_s2   <= dy12_s1 * dx34_s1;
			m1_s2   <= x1_s1 * y2_s1;
			m2_s2   <= y1_s1 * x2_s1;
			m3_s2   <= x3_s1 * y4_s1;
			m4_s2   <= y3_s1 * x4_s1;
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			dx34_s2 <= dx34_s1;
			dy34_s2 <= dy34_s1;
			lox_s2  <= lox_c;
			hix_s2  <= hix_c;
			loy_s2  <= loy_c;
			hiy_s2  <= hiy_c;

			den_s3  <= DW'(p1_s2) - DW'(p2_s2);
			c12_s3  <= CW'(m1_s2) - CW'(m2_s2);
			c34_s3  <= CW'(m3_s2) - CW'(m4_s2);
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			dx34_s3 <= dx34_s2;
			dy34_s3 <= dy34_s2;
			lox_s3  <= lox_s2;
			hix_s3  <= hix_s2;
			loy_s3  <= loy_s2;
			hiy_s3  <= hiy_s2;

			// cross products split into a signed high half and unsigned low half
			pxh_s4 <= $signed(c12_s3[CW-1:L]) * dx34_s3;
			pxl_s4 <= $signed({1'b0, c12_s3[L-1:0]}) * dx34_s3;
			qxh_s4 <= $signed(c34_s3[CW-1:L]) * dx12_s3;
			qxl_s4 <= $signed({1'b0, c34_s3[L-1:0]}) * dx12_s3;
			pyh_s4 <= $signed(c12_s3[CW-1:L]) * dy34_s3;
			pyl_s4 <= $signed({1'b0, c12_s3[L-1:0]}) * dy34_s3;
			qyh_s4 <= $signed(c34_s3[CW-1:L]) * dy12_s3;
			qyl_s4 <= $signed({1'b0, c34_s3[L-1:0]}) * dy12_s3;
			den_s4 <= den_s3;
			lox_s4 <= lox_s3;
			hix_s4 <= hix_s3;
			loy_s4 <= loy_s3;
			hiy_s4 <= hiy_s3;

			nx_s5  <= (NW'(pxh_s4) <<< L) + NW'(pxl_s4) - (NW'(qxh_s4) <<< L) - NW'(qxl_s4);
			ny_s5  <= (NW'(pyh_s4) <<< L) + NW'(pyl_s4) - (NW'(qyh_s4) <<< L) - NW'(qyl_s4);
			den_s5 <= den_s4;
			lox_s5 <= lox_s4;
			hix_s5 <= hix_s4;
			loy_s5 <= loy_s4;
			hiy_s5 <= hiy_s4;
		end
	end

endmodule

>>> src/sip_back.sv
// ----------------------------------------------------------------------------
// sip_back
// pipelined restoring divider, one quotient bit per stage, and range check
// ----------------------------------------------------------------------------
module sip_back import sip_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	localparam int FW = front_word_width(COORD_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [FW-1:0] word,
	input  sip_q_stat_t   q_stat,
	output logic          pop,
	sip_cross_if.source   result
);

	localparam int W  = COORD_WIDTH;
	localparam int E  = W + 1;
	localparam int DW = den_width(W);
	localparam int NW = num_width(W);

	typedef struct packed {
		logic [DW-1:0]       dm;
		logic                negx;
		logic                negy;
		logic                zero;
		logic                bigx;
		logic                bigy;
		logic signed [W-1:0] lox;
		logic signed [W-1:0] hix;
		logic signed [W-1:0] loy;
		logic signed [W-1:0] hiy;
	} side_t;

	logic en;

	logic signed [DW-1:0] den_w;
	logic signed [NW-1:0] nx_w, ny_w;
	logic signed [W-1:0]  lox_w, hix_w, loy_w, hiy_w;
	logic [NW-1:0]        nmx_c, nmy_c;
	logic [DW-1:0]        dm_c;

	// stage index k holds the word after k quotient bits
	logic          valid_s [W+1];
	side_t         side_s  [W+1];
	logic [NW-1:0] rx_s    [W+1];
	logic [NW-1:0] ry_s    [W+1];
	logic [W-1:0]  qx_s    [W+1];
	logic [W-1:0]  qy_s    [W+1];

	logic signed [E-1:0] sqx_c, sqy_c;
	logic                hit_c;

	logic                valid_q;
	logic                hit_q;
	logic signed [W-1:0] cross_x_q, cross_y_q;

	assign en  = !valid_q || result.ready;
	assign pop = !q_stat.empty && en;

	assign {den_w, nx_w, ny_w, lox_w, hix_w, loy_w, hiy_w} = word;

	assign nmx_c = nx_w[NW-1] ? (~nx_w + 1'b1) : nx_w;
	assign nmy_c = ny_w[NW-1] ? (~ny_w + 1'b1) : ny_w;
	assign dm_c  = den_w[DW-1] ? (~den_w + 1'b1) : den_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]        <= nmx_c;
			ry_s[0]        <= nmy_c;
			qx_s[0]        <= '0;
			qy_s[0]        <= '0;
			side_s[0].dm   <= dm_c;
			side_s[0].negx <= nx_w[NW-1] ^ den_w[DW-1];
			side_s[0].negy <= ny_w[NW-1] ^ den_w[DW-1];
			side_s[0].zero <= (den_w == '0);
			// quotient magnitude of 2**W or more can never land in range
			side_s[0].bigx <= (nmx_c >= (NW'(dm_c) << W));
			side_s[0].bigy <= (nmy_c >= (NW'(dm_c) << W));
			side_s[0].lox  <= lox_w;
			side_s[0].hix  <= hix_w;
			side_s[0].loy  <= loy_w;
			side_s[0].hiy  <= hiy_w;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_div
		logic [NW-1:0] dsh_c;
		logic          gex_c, gey_c;

		assign dsh_c = NW'(side_s[k].dm) << (W - 1 - k);
		assign gex_c = (rx_s[k] >= dsh_c);
		assign gey_c = (ry_s[k] >= dsh_c);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				rx_s[k+1]   <= gex_c ? (rx_s[k] - dsh_c) : rx_s[k];
				ry_s[k+1]   <= gey_c ? (ry_s[k] - dsh_c) : ry_s[k];
				qx_s[k+1]   <= qx_s[k] | (W'(gex_c) << (W - 1 - k));
				qy_s[k+1]   <= qy_s[k] | (W'(gey_c) << (W - 1 - k));
			end
		end
	end

	// signed quotient, truncated toward zero
	assign sqx_c = side_s[W].negx ? -$signed({1'b0, qx_s[W]}) : $signed({1'b0, qx_s[W]});
	assign sqy_c = side_s[W].negy ? -$signed({1'b0, qy_s[W]}) : $signed({1'b0, qy_s[W]});

	assign hit_c = !side_s[W].zero && !side_s[W].bigx && !side_s[W].bigy
		&& (sqx_c >= E'(side_s[W].lox)) && (sqx_c <= E'(side_s[W].hix))
		&& (sqy_c >= E'(side_s[W].loy)) && (sqy_c <= E'(side_s[W].hiy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q     <= hit_c;
			cross_x_q <= hit_c ? sqx_c[W-1:0] : '0;
			cross_y_q <= hit_c ? sqy_c[W-1:0] : '0;
		end
	end

	assign result.valid   = valid_q;
	assign result.hit     = hit_q;
	assign result.cross_x = cross_x_q;
	assign result.cross_y = cross_y_q;

endmodule

>>> sim/segment_intersection_point_checker.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_checker
// predicts each intersection word from the accepted pair words and compares
// ----------------------------------------------------------------------------
module segment_intersection_point_checker #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	sip_pair_if.sink  pair,
	sip_cross_if.sink result,
	output int        fail_count,
	output int        pending
);

	typedef struct {
		logic                          hit;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
	} cross_word_t;

	cross_word_t expected_crossings[$];

	function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
			input logic signed [127:0] d);
		logic signed [127:0] nm;
		logic signed [127:0] dm;
		logic signed [127:0] q;
		nm = n < 0 ? -n : n;
		dm = d < 0 ? -d : d;
		q = nm / dm;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic logic between(input logic signed [127:0] v,
			input logic signed [127:0] p1, input logic signed [127:0] p2,
			input logic signed [127:0] p3, input logic signed [127:0] p4);
		logic signed [127:0] lo;
		logic signed [127:0] hi;
		lo = (p1 < p2 ? p1 : p2);
		if ((p3 < p4 ? p3 : p4) > lo) lo = (p3 < p4 ? p3 : p4);
		hi = (p1 > p2 ? p1 : p2);
		if ((p3 > p4 ? p3 : p4) < hi) hi = (p3 > p4 ? p3 : p4);
		return v >= lo && v <= hi;
	endfunction

	function automatic cross_word_t predict_crossing(
			input logic signed [COORD_WIDTH-1:0] ax1, input logic signed [COORD_WIDTH-1:0] ay1,
			input logic signed [COORD_WIDTH-1:0] ax2, input logic signed [COORD_WIDTH-1:0] ay2,
			input logic signed [COORD_WIDTH-1:0] bx1, input logic signed [COORD_WIDTH-1:0] by1,
			input logic signed [COORD_WIDTH-1:0] bx2, input logic signed [COORD_WIDTH-1:0] by2);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
		logic signed [127:0] den, c12, c34, qx, qy;
		cross_word_t w;
		x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2;
		x3 = bx1; y3 = by1; x4 = bx2; y4 = by2;
		w = '{hit: 1'b0, cx: '0, cy: '0};
		den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
		if (den == 0) return w;
		c12 = x1 * y2 - y1 * x2;
		c34 = x3 * y4 - y3 * x4;
		qx = trunc_div(c12 * (x3 - x4) - (x1 - x2) * c34, den);
		qy = trunc_div(c12 * (y3 - y4) - (y1 - y2) * c34, den);
		// quotient must land inside both x and y overlaps
		if (!between(qx, x1, x2, x3, x4) || !between(qy, y1, y2, y3, y4)) return w;
		w.hit = 1'b1;
		w.cx = qx[COORD_WIDTH-1:0];
		w.cy = qy[COORD_WIDTH-1:0];
		return w;
	endfunction

	// append one predicted word at the tail
	function automatic void queue_crossing(input cross_word_t w);
		expected_crossings = {expected_crossings, w};
	endfunction

	assign pending = expected_crossings.size();

	always @(posedge clk) begin
		cross_word_t e;
		if (arst_n) begin
			if (pair.valid && pair.ready)
				queue_crossing(predict_crossing(pair.a_upper_x, pair.a_upper_y,
					pair.a_lower_x, pair.a_lower_y, pair.b_upper_x, pair.b_upper_y,
					pair.b_lower_x, pair.b_lower_y));
			if (result.valid && result.ready) begin
				if (expected_crossings.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result word hit=%0b x=%0d y=%0d",
							result.hit, result.cross_x, result.cross_y);
				end else begin
					e = expected_crossings.pop_front();
					if (e.hit !== result.hit || e.cx !== result.cross_x ||
							e.cy !== result.cross_y) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
								e.hit, e.cx, e.cy, result.hit, result.cross_x, result.cross_y);
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_segment_intersection_point_core.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_point_core
// streams segment pairs through the core with random idling on both sides
// ----------------------------------------------------------------------------
module tb_segment_intersection_point_core;

	localparam int CW = 16;
	localparam int LATENCY = CW + 8;
	localparam logic signed [CW-1:0] CMAX = 16'sh7fff;
	localparam logic signed [CW-1:0] CMIN = 16'sh8000;
	localparam logic signed [CW-1:0] CMIN_P1 = 16'sh8001;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   recv_idle_pct;

	sip_pair_if  #(.COORD_WIDTH(CW)) pair();
	sip_cross_if #(.COORD_WIDTH(CW)) result();

	segment_intersection_point_core #(.COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n), .pair(pair), .result(result)
	);

	segment_intersection_point_checker #(.COORD_WIDTH(CW)) checker_i (
		.clk(clk), .arst_n(arst_n), .pair(pair), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	// receiver side: random back-pressure at the current rate
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one pair word: waits for acceptance, sender idles at random before it
	task automatic send_pair(input logic signed [CW-1:0] ax1, input logic signed [CW-1:0] ay1,
			input logic signed [CW-1:0] ax2, input logic signed [CW-1:0] ay2,
			input logic signed [CW-1:0] bx1, input logic signed [CW-1:0] by1,
			input logic signed [CW-1:0] bx2, input logic signed [CW-1:0] by2);
		while ($urandom_range(99) < send_idle_pct) begin
			pair.valid <= 1'b0;
			@(posedge clk);
		end
		pair.valid <= 1'b1;
		pair.a_upper_x <= ax1; pair.a_upper_y <= ay1;
		pair.a_lower_x <= ax2; pair.a_lower_y <= ay2;
		pair.b_upper_x <= bx1; pair.b_upper_y <= by1;
		pair.b_lower_x <= bx2; pair.b_lower_y <= by2;
		// ready is settled mid-cycle, the word goes at the next rising edge
		@(negedge clk);
		while (!pair.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// random coordinate: mostly small so segments really cross, sometimes full range
	function automatic logic signed [CW-1:0] rand_coord(input int span);
		if (span == 0) return CW'($urandom);
		return CW'($signed($urandom_range(2 * span)) - span);
	endfunction

	// crossing pair built around a common point so hits are frequent
	task automatic send_random_pair();
		int span;
		logic signed [CW-1:0] c[8];
		span = ($urandom_range(9) == 0) ? 0 : ($urandom_range(3) == 0 ? 30000 : 64);
		for (int i = 0; i < 8; i++) c[i] = rand_coord(span);
		if (span != 0 && $urandom_range(2) != 0) begin
			// mirror endpoints around a centre so both segments straddle it
			c[2] = c[6] - c[0] + c[4];
			c[3] = c[7] - c[1] + c[5];
			c[0] = c[4];
			c[1] = c[7];
		end
		if ($urandom_range(19) == 0) begin
			// parallel copy of segment a
			c[4] = CW'(c[0] + 3); c[5] = CW'(c[1] + 1);
			c[6] = CW'(c[2] + 3); c[7] = CW'(c[3] + 1);
		end
		send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endtask

	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) send_random_pair();
		pair.valid <= 1'b0;
	endtask

	// wait mid-cycle until every predicted word has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pair.valid = 1'b0;
		pair.a_upper_x = '0; pair.a_upper_y = '0; pair.a_lower_x = '0; pair.a_lower_y = '0;
		pair.b_upper_x = '0; pair.b_upper_y = '0; pair.b_lower_x = '0; pair.b_lower_y = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: plain cross, parallel, collinear, disjoint, swapped ends, extremes
		send_pair(0, 0, 10, 10, 0, 10, 10, 0);
		send_pair(10, 10, 0, 0, 10, 0, 0, 10);
		send_pair(0, 0, 10, 0, 0, 5, 10, 5);
		send_pair(0, 0, 10, 10, 2, 2, 20, 20);
		send_pair(0, 0, 1, 1, 5, 0, 6, -1);
		send_pair(0, 0, 3, 1, 0, 1, 3, 0);
		send_pair(0, 0, -3, -1, 0, -1, -3, 0);
		send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
		send_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
		send_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
		send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
		send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
		send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
		send_pair(CMIN, CMAX, CMAX, CMIN_P1, CMAX, CMAX, CMIN, CMIN_P1);
		send_pair(0, 0, 0, 10, -5, 5, 5, 5);
		send_pair(0, 0, 4, 4, 4, 4, 8, 0);
		send_pair(1, 2, 30000, -30000, -30000, 2, 30000, 3);
		pair.valid <= 1'b0;

		// hold off until the core drains completely
		wait_drained();

		send_idle_pct = 10; recv_idle_pct = 83;
		run_phase(280);
		send_idle_pct = 83; recv_idle_pct = 10;
		run_phase(280);
		send_idle_pct = 0; recv_idle_pct = 0;
		run_phase(290);

		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
